/* rtl/profile_linear_interpolator_macros.svh */
// assertion macros for the profile interpolator
`ifndef PROFILE_LINEAR_INTERPOLATOR_MACROS_SVH
`define PROFILE_LINEAR_INTERPOLATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define PLI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pli_pkg.sv */
// shared constants and types for the profile interpolator
`timescale 1ns / 1ps

package pli_pkg;

  localparam int NUM_POINTS = 32;
  localparam int IDX_W      = $clog2(NUM_POINTS);
  localparam int VAL_W      = 32;
  localparam int DIFF_W     = VAL_W + 1;
  localparam int MAG_W      = VAL_W;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int QUO_W      = 34;
  localparam int DIV_STEPS  = QUO_W;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);
  localparam int SUM_W      = QUO_W + 1;

  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_POINTS - 1);

  // quotient clamp, 2^33
  localparam logic [QUO_W-1:0] QUO_CLAMP = {2'b10, {(QUO_W-2){1'b0}}};

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/profile_linear_interpolator.sv */
// profile point table with piecewise linear height lookup
`timescale 1ns / 1ps

// Stores up to 32 (position, height) points in signed Q23.8 and answers
// height queries by linear interpolation between the first point from
// index 1 on whose position is not below the query (else the last point)
// and the point before it. A write request (in_op = 0) gives no result and
// leaves busy low. A query request holds busy high through a scan of the
// table, one point at a time, then a fetch and subtract, a 32x32 multiply,
// and a radix-2 divider taking 34 steps; the divider does not iterate when
// the quotient would overflow and is skipped for a zero-length segment. The
// result shows on out_height, out_segment and out_saturated for exactly one
// cycle with out_valid; the receiver cannot stall it, so it must take it in
// that cycle. Table entries are not cleared by reset: every entry a query
// touches has to be written first.
`include "profile_linear_interpolator_macros.svh"

module profile_linear_interpolator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_op,
  input  logic [pli_pkg::IDX_W-1:0]        in_point_index,
  input  logic signed [pli_pkg::VAL_W-1:0] in_point_pos,
  input  logic signed [pli_pkg::VAL_W-1:0] in_point_height,
  input  logic signed [pli_pkg::VAL_W-1:0] in_query_pos,
  output logic                             out_valid,
  output logic signed [pli_pkg::VAL_W-1:0] out_height,
  output logic [pli_pkg::IDX_W-1:0]        out_segment,
  output logic                             out_saturated
);
  import pli_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_LOW  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // point table, position in the upper half
  logic [2*VAL_W-1:0] mem [NUM_POINTS];
  logic [2*VAL_W-1:0] rd_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               accept;
  logic               wr_en;

  logic signed [VAL_W-1:0]  q_r;
  logic signed [VAL_W-1:0]  y2_r;
  logic signed [VAL_W-1:0]  z2_r;
  logic signed [VAL_W-1:0]  z1_r;
  logic signed [DIFF_W-1:0] dy_r;
  logic signed [DIFF_W-1:0] dz_r;
  logic signed [DIFF_W-1:0] dq_r;
  logic [IDX_W-1:0]         idx_r;
  logic [PROD_W-1:0]        prod_r;
  logic [MAG_W-1:0]         mdy_r;
  logic                     neg_r;
  logic                     flat_r;

  logic signed [VAL_W-1:0]  rd_pos;
  logic signed [VAL_W-1:0]  rd_height;
  logic                     scan_more;
  logic [DIFF_W-1:0]        neg_dz;
  logic [DIFF_W-1:0]        neg_dq;
  logic [DIFF_W-1:0]        neg_dy;
  logic [MAG_W-1:0]         mag_dz;
  logic [MAG_W-1:0]         mag_dq;
  logic [MAG_W-1:0]         mag_dy;

  div_ctrl_t                div_ctrl;
  div_stat_t                div_stat;
  logic [QUO_W-1:0]         quo;
  logic                     div_run_seen_r;

  logic signed [SUM_W-1:0]  z1_ext;
  logic signed [SUM_W-1:0]  quo_ext;
  logic signed [SUM_W-1:0]  sum;
  logic signed [VAL_W-1:0]  res;
  logic                     sat;

  logic                     out_valid_r;
  logic signed [VAL_W-1:0]  out_height_r;
  logic [IDX_W-1:0]         out_segment_r;
  logic                     out_saturated_r;

  assign accept    = start && (state_r == ST_IDLE);
  assign wr_en     = accept && (in_op == OP_WRITE);
  assign rd_pos    = rd_r[2*VAL_W-1:VAL_W];
  assign rd_height = rd_r[VAL_W-1:0];
  assign scan_more = (idx_r < IDX_LAST) && (rd_pos < q_r);

  always_comb begin
    rd_addr = idx_r;
    unique case (state_r)
      ST_IDLE: rd_addr = IDX_FIRST;
      ST_SCAN: rd_addr = scan_more ? (idx_r + IDX_W'(1)) : (idx_r - IDX_W'(1));
      ST_LOW, ST_MUL, ST_DIV, ST_FIN: rd_addr = idx_r;
      default: rd_addr = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_point_index] <= {in_point_pos, in_point_height};
    end
    rd_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && in_op == OP_QUERY) state_nxt = ST_SCAN;
      ST_SCAN: if (!scan_more) state_nxt = ST_LOW;
      ST_LOW:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = flat_r ? ST_FIN : ST_DIV;
      ST_DIV:  if (div_stat.done) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_FIN);
    end
  end

  // magnitudes of the segment differences, each fits 32 bits
  assign neg_dz = -dz_r;
  assign neg_dq = -dq_r;
  assign neg_dy = -dy_r;
  assign mag_dz = dz_r[DIFF_W-1] ? neg_dz[MAG_W-1:0] : dz_r[MAG_W-1:0];
  assign mag_dq = dq_r[DIFF_W-1] ? neg_dq[MAG_W-1:0] : dq_r[MAG_W-1:0];
  assign mag_dy = dy_r[DIFF_W-1] ? neg_dy[MAG_W-1:0] : dy_r[MAG_W-1:0];

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        q_r   <= in_query_pos;
        idx_r <= IDX_FIRST;
      end
      ST_SCAN: begin
        if (scan_more) begin
          idx_r <= idx_r + IDX_W'(1);
        end else begin
          y2_r <= rd_pos;
          z2_r <= rd_height;
        end
      end
      ST_LOW: begin
        z1_r   <= rd_height;
        dy_r   <= DIFF_W'(y2_r) - DIFF_W'(rd_pos);
        dz_r   <= DIFF_W'(z2_r) - DIFF_W'(rd_height);
        dq_r   <= DIFF_W'(q_r) - DIFF_W'(rd_pos);
        flat_r <= (y2_r == rd_pos);
      end
      ST_MUL: begin
        prod_r <= PROD_W'(mag_dz) * PROD_W'(mag_dq);
        mdy_r  <= mag_dy;
        neg_r  <= (dz_r[DIFF_W-1] ^ dq_r[DIFF_W-1]) ^ dy_r[DIFF_W-1];
      end
      ST_DIV, ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  assign div_ctrl.start = (state_r == ST_DIV) && !div_stat.busy && !div_stat.done
                          && !div_run_seen_r;

  // one start per query: remember that the divider was launched
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_run_seen_r <= 1'b0;
    end else if (state_r != ST_DIV) begin
      div_run_seen_r <= 1'b0;
    end else if (div_ctrl.start) begin
      div_run_seen_r <= 1'b1;
    end
  end

  pli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (prod_r),
    .divisor  (mdy_r),
    .stat     (div_stat),
    .quotient (quo)
  );

  assign z1_ext  = SUM_W'(z1_r);
  assign quo_ext = SUM_W'(quo);
  assign sum     = flat_r ? z1_ext : (neg_r ? (z1_ext - quo_ext) : (z1_ext + quo_ext));

  always_comb begin
    res = sum[VAL_W-1:0];
    sat = 1'b0;
    priority if (sum > SUM_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}))) begin
      res = {1'b0, {(VAL_W-1){1'b1}}};
      sat = 1'b1;
    end else if (sum < -(SUM_W'(signed'({1'b0, 1'b1, {(VAL_W-1){1'b0}}})))) begin
      res = {1'b1, {(VAL_W-1){1'b0}}};
      sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN) begin
      out_height_r    <= res;
      out_segment_r   <= idx_r;
      out_saturated_r <= sat;
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_height    = out_height_r;
  assign out_segment   = out_segment_r;
  assign out_saturated = out_saturated_r;

  `PLI_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `PLI_ASSERT_NEXT(a_query_busy, start && !busy && in_op == OP_QUERY, busy, "query not taken")
  `PLI_ASSERT_SAME(a_segment_upper, out_valid, out_segment != '0, "segment index zero")
  `PLI_ASSERT_SAME(a_idle_on_result, out_valid, !busy, "busy while result shown")

endmodule

/* rtl/pli_div.sv */
// radix-2 restoring divider with quotient clamp
`timescale 1ns / 1ps

module pli_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pli_pkg::div_ctrl_t        ctrl,
  input  logic [pli_pkg::PROD_W-1:0] dividend,
  input  logic [pli_pkg::MAG_W-1:0]  divisor,
  output pli_pkg::div_stat_t        stat,
  output logic [pli_pkg::QUO_W-1:0]  quotient
);
  import pli_pkg::*;

  localparam int HI_W = PROD_W - QUO_W;

  logic [MAG_W:0]   rem_r;
  logic [QUO_W-1:0] qd_r;
  logic [MAG_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic             ovf_r;

  logic [MAG_W:0]   shifted;
  logic             fits;
  logic             ovf_nxt;

  assign ovf_nxt = {{(MAG_W-HI_W){1'b0}}, dividend[PROD_W-1:QUO_W]} >= divisor;
  assign shifted = {rem_r[MAG_W-1:0], qd_r[QUO_W-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        // quotient would reach 2^34: clamp without iterating
        run_r  <= !ovf_nxt;
        done_r <= ovf_nxt;
        cnt_r  <= CNT_W'(DIV_STEPS);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem_r <= {{(MAG_W+1-HI_W){1'b0}}, dividend[PROD_W-1:QUO_W]};
      qd_r  <= dividend[QUO_W-1:0];
      dvs_r <= divisor;
      ovf_r <= ovf_nxt;
    end else if (run_r) begin
      rem_r <= fits ? (shifted - {1'b0, dvs_r}) : shifted;
      qd_r  <= {qd_r[QUO_W-2:0], fits};
    end
  end

  assign quotient  = (ovf_r || qd_r > QUO_CLAMP) ? QUO_CLAMP : qd_r;
  assign stat.busy = run_r;
  assign stat.done = done_r;

endmodule
